// ===== hw/rtl/euclidean_odometer_accumulator_top_defines.svh =====
// assertion macros used by the top-level rtl file
`ifndef EUCLIDEAN_ODOMETER_ACCUMULATOR_TOP_DEFINES_SVH
`define EUCLIDEAN_ODOMETER_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define EOA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("eoa assertion failed");
`define EOA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eoa assertion failed");
`else
`define EOA_ASSERT(lbl, prop)
`define EOA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/eoa_pkg.sv =====
package eoa_pkg;

    localparam int POS_W   = 24;
    localparam int TOTAL_W = 48;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 25;

    localparam int SQ_W    = 2 * POS_W;
    localparam int RAD_W   = SQ_W + 1;
    localparam int STEPS   = (RAD_W + 1) / 2;
    localparam int ROOT_W  = STEPS;
    localparam int PAD_W   = 2 * STEPS;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CNT_W   = $clog2(STEPS + 1);
    localparam int ACC_W   = ((TOTAL_W > ROOT_W) ? TOTAL_W : ROOT_W) + 1;

    localparam logic [TIME_W-1:0] STALE_LIMIT_RESET = 32'd10000;

    localparam logic [1:0] KIND_SET_X = 2'd0;
    localparam logic [1:0] KIND_SET_Y = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [POS_W-1:0] position_value;
        logic [TIME_W-1:0]       time_ms;
    } eoa_in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_distance;
        logic [STEP_W-1:0]  step_distance;
        logic               published;
        logic               stale;
    } eoa_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eoa_root_stat_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQX  = 7'b0000010,
        ST_SQY  = 7'b0000100,
        ST_SUM  = 7'b0001000,
        ST_ROOT = 7'b0010000,
        ST_ACC  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } eoa_state_t;

endpackage

// ===== hw/rtl/eoa_sqrt.sv =====
module eoa_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [eoa_pkg::RAD_W-1:0]   radicand,
    output eoa_pkg::eoa_root_stat_t     stat,
    output logic [eoa_pkg::ROOT_W-1:0]  root
);

    logic [eoa_pkg::PAD_W-1:0]  rad_reg, rad_next;
    logic [eoa_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [eoa_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [eoa_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [eoa_pkg::REM_W-1:0]  rem_sh;
    logic [eoa_pkg::REM_W-1:0]  trial;
    logic                       ge;

    // one root bit per cycle, restoring method
    assign rem_sh = {rem_reg[eoa_pkg::REM_W-3:0], rad_reg[eoa_pkg::PAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = eoa_pkg::PAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = eoa_pkg::CNT_W'(eoa_pkg::STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[eoa_pkg::PAD_W-3:0], 2'b00};
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[eoa_pkg::ROOT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == eoa_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ===== hw/rtl/euclidean_odometer_accumulator_top.sv =====
// euclidean distance odometer
// req channel (valid/ready, eoa_in_t): kind set x, set y or tick, with a
// signed position and a millisecond time; kind 3 is dropped
// rsp channel (valid/ready, eoa_out_t): one beat per tick carrying the
// saturating total, the step just added, a published flag and a stale flag
// cfg channel (valid/ready, always ready): writes stale_limit_ms
// position updates and kind 3 are taken while idle and req_ready stays
// high, so they can follow back to back
// the first tick after reset latches the position and goes to the emit
// state with a zero step; req_ready returns once its result is registered
// every later tick squares dx and dy on one shared multiplier, then runs the
// 25 one-bit steps of the square root unit, then accumulates and emits;
// req_ready likewise returns once its result is registered
// the result sits in an output register; new items are taken while it
// waits, and a finished tick holds in its last state until the rsp slot
// is free
// reset clears positions, total, times and the first-tick flag and sets
// stale_limit_ms to 10000
`include "euclidean_odometer_accumulator_top_defines.svh"

module euclidean_odometer_accumulator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  eoa_pkg::eoa_in_t            req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output eoa_pkg::eoa_out_t           rsp_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [eoa_pkg::TIME_W-1:0]  cfg_data
);

    eoa_pkg::eoa_state_t state_reg, state_next;

    logic [eoa_pkg::TIME_W-1:0]  limit_reg, limit_next;
    logic [eoa_pkg::POS_W-1:0]   cur_x_reg, cur_x_next;
    logic [eoa_pkg::POS_W-1:0]   cur_y_reg, cur_y_next;
    logic [eoa_pkg::POS_W-1:0]   prev_x_reg, prev_x_next;
    logic [eoa_pkg::POS_W-1:0]   prev_y_reg, prev_y_next;
    logic                        seen_reg, seen_next;
    logic [eoa_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [eoa_pkg::TIME_W-1:0]  last_reg, last_next;

    logic [eoa_pkg::POS_W-1:0]   dx_reg, dx_next;
    logic [eoa_pkg::POS_W-1:0]   dy_reg, dy_next;
    logic [eoa_pkg::SQ_W-1:0]    sqa_reg, sqa_next;
    logic [eoa_pkg::SQ_W-1:0]    sqb_reg, sqb_next;
    logic [eoa_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        pub_reg, pub_next;
    logic                        stale_reg, stale_next;

    logic                        rsp_valid_reg, rsp_valid_next;
    eoa_pkg::eoa_out_t           rsp_data_reg, rsp_data_next;

    logic [eoa_pkg::POS_W-1:0]   ux, upx, uy, upy;
    logic [eoa_pkg::POS_W-1:0]   mul_op;
    logic [eoa_pkg::SQ_W-1:0]    prod;
    logic [eoa_pkg::RAD_W-1:0]   radicand;
    logic [eoa_pkg::ACC_W-1:0]   acc_sum;
    logic                        acc_sat;
    logic                        emit_fire;
    logic                        root_start;
    logic [eoa_pkg::ROOT_W-1:0]  root;
    eoa_pkg::eoa_root_stat_t     root_stat;

    // offset binary so signed values compare as unsigned
    assign ux  = {~cur_x_reg[eoa_pkg::POS_W-1],  cur_x_reg[eoa_pkg::POS_W-2:0]};
    assign upx = {~prev_x_reg[eoa_pkg::POS_W-1], prev_x_reg[eoa_pkg::POS_W-2:0]};
    assign uy  = {~cur_y_reg[eoa_pkg::POS_W-1],  cur_y_reg[eoa_pkg::POS_W-2:0]};
    assign upy = {~prev_y_reg[eoa_pkg::POS_W-1], prev_y_reg[eoa_pkg::POS_W-2:0]};

    // shared squaring multiplier
    assign mul_op   = (state_reg == eoa_pkg::ST_SQX) ? dx_reg : dy_reg;
    assign prod     = mul_op * mul_op;
    assign radicand = {1'b0, sqa_reg} + {1'b0, sqb_reg};

    assign acc_sum  = eoa_pkg::ACC_W'(total_reg) + eoa_pkg::ACC_W'(root);
    assign acc_sat  = acc_sum > eoa_pkg::ACC_W'({eoa_pkg::TOTAL_W{1'b1}});

    assign emit_fire = (state_reg == eoa_pkg::ST_EMIT) && (!rsp_valid_reg || rsp_ready);
    assign root_start = (state_reg == eoa_pkg::ST_SUM);

    eoa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .stat     (root_stat),
        .root     (root)
    );

    always_comb
    begin
        state_next     = state_reg;
        limit_next     = limit_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        seen_next      = seen_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sqa_next       = sqa_reg;
        sqb_next       = sqb_reg;
        step_next      = step_reg;
        pub_next       = pub_reg;
        stale_next     = stale_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        unique case (state_reg)
            eoa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_data.kind)
                        eoa_pkg::KIND_SET_X:
                        begin
                            cur_x_next = req_data.position_value;
                            last_next  = req_data.time_ms;
                        end
                        eoa_pkg::KIND_SET_Y:
                        begin
                            cur_y_next = req_data.position_value;
                            last_next  = req_data.time_ms;
                        end
                        eoa_pkg::KIND_TICK:
                        begin
                            dx_next     = (ux >= upx) ? (ux - upx) : (upx - ux);
                            dy_next     = (uy >= upy) ? (uy - upy) : (upy - uy);
                            stale_next  = {1'b0, req_data.time_ms} >
                                          ({1'b0, last_reg} + {1'b0, limit_reg});
                            prev_x_next = cur_x_reg;
                            prev_y_next = cur_y_reg;
                            seen_next   = 1'b1;
                            if (seen_reg)
                            begin
                                state_next = eoa_pkg::ST_SQX;
                            end
                            else
                            begin
                                step_next  = '0;
                                pub_next   = 1'b0;
                                state_next = eoa_pkg::ST_EMIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            eoa_pkg::ST_SQX:
            begin
                sqa_next   = prod;
                state_next = eoa_pkg::ST_SQY;
            end
            eoa_pkg::ST_SQY:
            begin
                sqb_next   = prod;
                state_next = eoa_pkg::ST_SUM;
            end
            eoa_pkg::ST_SUM:
            begin
                state_next = eoa_pkg::ST_ROOT;
            end
            eoa_pkg::ST_ROOT:
            begin
                if (root_stat.done)
                begin
                    state_next = eoa_pkg::ST_ACC;
                end
            end
            eoa_pkg::ST_ACC:
            begin
                total_next = acc_sat ? {eoa_pkg::TOTAL_W{1'b1}}
                                     : acc_sum[eoa_pkg::TOTAL_W-1:0];
                step_next  = eoa_pkg::STEP_W'(root);
                pub_next   = 1'b1;
                state_next = eoa_pkg::ST_EMIT;
            end
            eoa_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    rsp_data_next.total_distance = total_reg;
                    rsp_data_next.step_distance  = step_reg;
                    rsp_data_next.published      = pub_reg;
                    rsp_data_next.stale          = stale_reg;
                    rsp_valid_next               = 1'b1;
                    state_next                   = eoa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = eoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= eoa_pkg::ST_IDLE;
            limit_reg     <= eoa_pkg::STALE_LIMIT_RESET;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            seen_reg      <= 1'b0;
            total_reg     <= '0;
            last_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            seen_reg      <= seen_next;
            total_reg     <= total_next;
            last_reg      <= last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sqa_reg      <= sqa_next;
        sqb_reg      <= sqb_next;
        step_reg     <= step_next;
        pub_reg      <= pub_next;
        stale_reg    <= stale_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign req_ready = (state_reg == eoa_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    `EOA_ASSERT(a_root_running, (state_reg != eoa_pkg::ST_ROOT) || root_stat.busy || root_stat.done)
    `EOA_ASSERT_NEXT(a_first_tick, req_valid && req_ready && (req_data.kind == eoa_pkg::KIND_TICK) && !seen_reg, state_reg == eoa_pkg::ST_EMIT)
    `EOA_ASSERT_NEXT(a_emit_loads, emit_fire, rsp_valid && (state_reg == eoa_pkg::ST_IDLE))
    `EOA_ASSERT(a_unpub_zero, !rsp_valid || rsp_data.published || (rsp_data.step_distance == '0))

endmodule
